// ===== rtl/postfix_integer_evaluator_defines.svh =====
// Assertion macros for the postfix integer evaluator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef POSTFIX_INTEGER_EVALUATOR_DEFINES_SVH
`define POSTFIX_INTEGER_EVALUATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define PIE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("postfix evaluator: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define PIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("postfix evaluator: next-cycle check failed");
// Condition that must hold at every edge out of reset.
`define PIE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("postfix evaluator: invariant failed");
`else
`define PIE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PIE_ASSERT_NEXT(label, clk, rst, ante, cons)
`define PIE_ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

// ===== rtl/pie_pkg.sv =====
// Shared constants and helper functions for the postfix integer evaluator.
// No dependencies; used by the channel interfaces and the top level.
package pie_pkg;

   // Payload widths.
   localparam int CHAR_W   = 8;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;

   // Default operand stack depth.
   localparam int STACK_DEPTH_DEFAULT = 16;

   // Character codes that the evaluator recognises.
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

   // Status codes of a result.
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

   // True for a decimal digit.
   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // True for one of the four operator characters.
   function automatic logic is_operator(input logic [CHAR_W-1:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) || (c == CHAR_SLASH);
   endfunction

endpackage

// ===== rtl/pie_channels.sv =====
// Valid/ready channel interfaces for the postfix integer evaluator.
// Depends on pie_pkg for the payload widths.

// Character request channel.
interface pie_req_if;
   logic                          valid;
   logic                          ready;
   logic [pie_pkg::CHAR_W-1:0]    char_code;
   logic                          end_of_expr;

   modport source (output valid, output char_code, output end_of_expr, input ready);
   modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

// Result channel.
interface pie_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pie_pkg::WORD_W-1:0] value;
   logic [pie_pkg::STATUS_W-1:0]      status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== rtl/postfix_integer_evaluator.sv =====
// Top level of the postfix integer evaluator: sequencer, operand stack memory and divider.
// Depends on pie_pkg, pie_channels.sv and postfix_integer_evaluator_defines.svh.

// The block takes one character per request and evaluates a reverse-Polish integer
// expression with 32-bit wrapping arithmetic; the request marked end_of_expr yields one
// result (top of stack and status) and clears the state for the next expression.
// Digits and skipped characters are handled in S_IDLE; a number that a non-digit
// ends is pushed in S_FLUSH. Operators + - and * pass S_OP, S_RD2, S_EXEC and S_PUSH, as
// the two operands are read one after the other through the single read port of the
// stack memory. Division adds S_DIV, where the restoring divider makes one quotient
// bit a cycle, and S_DIV_FIX. S_END, S_END_WAIT and S_RESULT read the top of stack and
// load the result register. A finished result waits in the output register while the
// next request is already being taken; only a further result stalls behind it.
`include "postfix_integer_evaluator_defines.svh"

module postfix_integer_evaluator #(
   parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   pie_req_if.sink          req_ch,
   pie_rsp_if.source        rsp_ch
);

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int W      = pie_pkg::WORD_W;
   localparam int CW     = pie_pkg::CHAR_W;
   localparam int SW     = pie_pkg::STATUS_W;

   typedef enum logic [3:0] {
      S_IDLE, S_FLUSH, S_OP, S_RD2, S_EXEC, S_DIV, S_DIV_FIX, S_PUSH,
      S_END, S_END_WAIT, S_RESULT
   } state_type;

   // Operand stack memory with registered read data.
   logic [W-1:0]      stack_mem [STACK_DEPTH];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [W-1:0]      mem_wd;
   logic [ADDR_W-1:0] rd_addr;
   logic [W-1:0]      rd_data_ff;

   // Sequencer state and registered outputs.
   state_type     state_ff, state_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic          in_number_ff, in_number_in;
   logic [SW-1:0] sticky_ff, sticky_in;
   logic [CW-1:0] char_ff, char_in;
   logic          last_ff, last_in;
   logic [W-1:0]  rhs_ff, rhs_in;
   logic [W-1:0]  res_ff, res_in;
   logic [SW-1:0] fin_status_ff, fin_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  value_ff, value_in;
   logic [SW-1:0] status_ff, status_in;

   // Divider registers.
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic [4:0]    cnt_ff, cnt_in;

   // Combinational helpers.
   logic [SP_W-1:0] sp_m1, sp_m2;
   logic [W-1:0]    lhs;
   logic [W-1:0]    acc_next;
   logic [W:0]      div_shifted;
   logic [W:0]      div_diff;
   logic            out_free;
   logic            stack_full;

   assign sp_m1      = sp_ff - SP_W'(1);
   assign sp_m2      = sp_ff - SP_W'(2);
   assign lhs        = rd_data_ff;
   assign acc_next   = (acc_ff << 3) + (acc_ff << 1)
                       + W'(req_ch.char_code - pie_pkg::CHAR_ZERO);
   assign div_shifted = {rem_ff, quo_ff[W-1]};
   assign div_diff    = div_shifted - {1'b0, dvs_ff};
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign stack_full  = (sp_ff >= SP_W'(STACK_DEPTH));

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = value_ff;
   assign rsp_ch.status = status_ff;

   // Next-state and datapath logic of the sequencer.
   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      acc_in        = acc_ff;
      in_number_in  = in_number_ff;
      sticky_in     = sticky_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      rhs_in        = rhs_ff;
      res_in        = res_ff;
      fin_status_in = fin_status_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      mem_we        = 1'b0;
      mem_wa        = sp_ff[ADDR_W-1:0];
      mem_wd        = acc_ff;
      rd_addr       = sp_m1[ADDR_W-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               char_in = req_ch.char_code;
               last_in = req_ch.end_of_expr;
               if (pie_pkg::is_digit(req_ch.char_code)) begin
                  acc_in       = acc_next;
                  in_number_in = 1'b1;
                  if (req_ch.end_of_expr) begin
                     state_in = S_FLUSH;
                  end
               end else if (in_number_ff) begin
                  state_in = S_FLUSH;
               end else if (pie_pkg::is_operator(req_ch.char_code)) begin
                  state_in = S_OP;
               end else if (req_ch.end_of_expr) begin
                  state_in = S_END;
               end
            end
         end

         // Push the pending number, dropping it on a full stack.
         S_FLUSH: begin
            if (stack_full) begin
               if (sticky_ff == pie_pkg::ST_OK) begin
                  sticky_in = pie_pkg::ST_OVER;
               end
            end else begin
               mem_we = 1'b1;
               mem_wd = acc_ff;
               sp_in  = sp_ff + SP_W'(1);
            end
            acc_in       = '0;
            in_number_in = 1'b0;
            if (pie_pkg::is_operator(char_ff)) begin
               state_in = S_OP;
            end else if (last_ff) begin
               state_in = S_END;
            end else begin
               state_in = S_IDLE;
            end
         end

         // Check for two operands and start reading the right-hand one.
         S_OP: begin
            if (sp_ff < SP_W'(2)) begin
               if (sticky_ff == pie_pkg::ST_OK) begin
                  sticky_in = pie_pkg::ST_UNDER;
               end
               state_in = last_ff ? S_END : S_IDLE;
            end else begin
               rd_addr  = sp_m1[ADDR_W-1:0];
               state_in = S_RD2;
            end
         end

         // Right-hand operand arrives; read the left-hand one.
         S_RD2: begin
            rhs_in   = rd_data_ff;
            rd_addr  = sp_m2[ADDR_W-1:0];
            state_in = S_EXEC;
         end

         // Apply the operator, or set up the divider.
         S_EXEC: begin
            sp_in    = sp_m2;
            state_in = S_PUSH;
            unique case (char_ff)
               pie_pkg::CHAR_PLUS:  res_in = lhs + rhs_ff;
               pie_pkg::CHAR_MINUS: res_in = lhs - rhs_ff;
               pie_pkg::CHAR_STAR:  res_in = lhs * rhs_ff;
               default: begin
                  if (rhs_ff == '0) begin
                     res_in = '0;
                     if (sticky_ff == pie_pkg::ST_OK) begin
                        sticky_in = pie_pkg::ST_DIVZ;
                     end
                  end else begin
                     quo_in   = lhs[W-1] ? W'(0) - lhs : lhs;
                     dvs_in   = rhs_ff[W-1] ? W'(0) - rhs_ff : rhs_ff;
                     neg_in   = lhs[W-1] ^ rhs_ff[W-1];
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
               end
            endcase
         end

         // One restoring division step per cycle on the magnitudes.
         S_DIV: begin
            if (!div_diff[W]) begin
               rem_in = div_diff[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = div_shifted[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_DIV_FIX;
            end
         end

         // Restore the sign of the quotient.
         S_DIV_FIX: begin
            res_in   = neg_ff ? W'(0) - quo_ff : quo_ff;
            state_in = S_PUSH;
         end

         // Push the operation result.
         S_PUSH: begin
            if (stack_full) begin
               if (sticky_ff == pie_pkg::ST_OK) begin
                  sticky_in = pie_pkg::ST_OVER;
               end
            end else begin
               mem_we = 1'b1;
               mem_wd = res_ff;
               sp_in  = sp_ff + SP_W'(1);
            end
            state_in = last_ff ? S_END : S_IDLE;
         end

         // Settle the status and read the top of stack when it is needed.
         S_END: begin
            res_in = '0;
            if (sticky_ff != pie_pkg::ST_OK) begin
               fin_status_in = sticky_ff;
               state_in      = S_RESULT;
            end else if (sp_ff == '0) begin
               fin_status_in = pie_pkg::ST_EMPTY;
               state_in      = S_RESULT;
            end else begin
               fin_status_in = pie_pkg::ST_OK;
               rd_addr       = sp_m1[ADDR_W-1:0];
               state_in      = S_END_WAIT;
            end
         end

         S_END_WAIT: begin
            res_in   = rd_data_ff;
            state_in = S_RESULT;
         end

         // Load the output register and clear for the next expression.
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               value_in     = res_ff;
               status_in    = fin_status_ff;
               sp_in        = '0;
               acc_in       = '0;
               in_number_in = 1'b0;
               sticky_in    = pie_pkg::ST_OK;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, control and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         acc_ff       <= '0;
         in_number_ff <= 1'b0;
         sticky_ff    <= pie_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         acc_ff       <= acc_in;
         in_number_ff <= in_number_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      char_ff       <= char_in;
      last_ff       <= last_in;
      rhs_ff        <= rhs_in;
      res_ff        <= res_in;
      fin_status_ff <= fin_status_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      neg_ff        <= neg_in;
   end

   // Stack memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // The stack pointer never passes the depth of the stack.
   `PIE_ASSERT_ALWAYS(a_sp_bound, clock, reset, sp_ff <= SP_W'(STACK_DEPTH))
   // Loading a result leaves the evaluator cleared.
   `PIE_ASSERT_NEXT(a_clear_after_result, clock, reset, state_ff == S_RESULT && out_free, sp_ff == '0 && !in_number_ff && acc_ff == '0 && sticky_ff == pie_pkg::ST_OK)
   // The first error of an expression is kept until its result is formed.
   `PIE_ASSERT_NEXT(a_sticky_holds, clock, reset, sticky_ff != pie_pkg::ST_OK && state_ff != S_RESULT, sticky_ff == $past(sticky_ff))
   // An operator is only executed with two operands on the stack.
   `PIE_ASSERT_IMPLIES(a_exec_operands, clock, reset, state_ff == S_EXEC, sp_ff >= SP_W'(2))

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the postfix integer evaluator: drives character requests,
// predicts every result with a stack machine of its own and checks the result channel.
// Depends on pie_pkg, the channel interfaces in pie_channels.sv and the evaluator RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH            = pie_pkg::STACK_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS     = 1220;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int DRAIN_CYCLES     = 60;
   localparam int QUIET_TAIL_ITEMS = 150;
   localparam int CALM_FIRST       = 300;
   localparam int CALM_LAST        = 450;

   localparam logic [pie_pkg::CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [pie_pkg::CHAR_W-1:0] OPERATOR_CHARS [4] =
      '{pie_pkg::CHAR_PLUS, pie_pkg::CHAR_MINUS, pie_pkg::CHAR_STAR, pie_pkg::CHAR_SLASH};

   typedef struct {
      logic [pie_pkg::CHAR_W-1:0] code;
      logic                       last;
      bit                         wait_idle;
   } char_item_type;

   typedef struct {
      logic [pie_pkg::WORD_W-1:0]   value;
      logic [pie_pkg::STATUS_W-1:0] status;
   } eval_result_type;

   // Clock, reset and the two channels.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   pie_req_if req_ch ();
   pie_rsp_if rsp_ch ();

   postfix_integer_evaluator #(.STACK_DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Requests waiting to be sent, results still to arrive, and run bookkeeping.
   char_item_type              char_queue [$];
   eval_result_type            results_due [$];
   logic [pie_pkg::CHAR_W-1:0] expr_buf [$];
   int                chars_sent      = 0;
   int                expressions     = 0;
   int                results_checked = 0;
   int                failures        = 0;
   int                tail_start      = 0;
   int                send_gap        = 0;
   int                rsp_stall       = 0;
   int                idle_cycles     = 0;
   int                status_seen [5] = '{default: 0};

   // Predicted evaluator state.
   logic [pie_pkg::WORD_W-1:0]   operands [DEPTH];
   int unsigned                  depth_used;
   logic [pie_pkg::WORD_W-1:0]   digits_acc;
   bit                           in_digits;
   logic [pie_pkg::STATUS_W-1:0] first_fault;

   function automatic bit is_operator_char(input logic [pie_pkg::CHAR_W-1:0] c);
      return c == pie_pkg::CHAR_PLUS || c == pie_pkg::CHAR_MINUS ||
             c == pie_pkg::CHAR_STAR || c == pie_pkg::CHAR_SLASH;
   endfunction

   function automatic bit is_digit_char(input logic [pie_pkg::CHAR_W-1:0] c);
      return c >= pie_pkg::CHAR_ZERO && c <= pie_pkg::CHAR_NINE;
   endfunction

   function automatic void clear_evaluation();
      depth_used  = 0;
      digits_acc  = '0;
      in_digits   = 1'b0;
      first_fault = pie_pkg::ST_OK;
   endfunction

   // Only the first fault of an expression is reported.
   function automatic void record_fault(input logic [pie_pkg::STATUS_W-1:0] code);
      if (first_fault == pie_pkg::ST_OK) first_fault = code;
   endfunction

   // A push onto a full stack loses the word.
   function automatic void push_operand(input logic [pie_pkg::WORD_W-1:0] w);
      if (depth_used >= DEPTH) begin
         record_fault(pie_pkg::ST_OVER);
      end else begin
         operands[depth_used] = w;
         depth_used++;
      end
   endfunction

   // Division on magnitudes, so that the most negative word over minus one wraps cleanly.
   function automatic logic [pie_pkg::WORD_W-1:0] quotient_toward_zero(
         input logic [pie_pkg::WORD_W-1:0] a, input logic [pie_pkg::WORD_W-1:0] b);
      logic [pie_pkg::WORD_W-1:0] mag_a, mag_b, q;
      mag_a = a[pie_pkg::WORD_W-1] ? -a : a;
      mag_b = b[pie_pkg::WORD_W-1] ? -b : b;
      q     = mag_a / mag_b;
      return (a[pie_pkg::WORD_W-1] != b[pie_pkg::WORD_W-1]) ? -q : q;
   endfunction

   // The second word popped is the left operand; too few operands leaves the stack alone.
   function automatic void apply_operator(input logic [pie_pkg::CHAR_W-1:0] c);
      logic [pie_pkg::WORD_W-1:0] lhs, rhs, res;
      if (depth_used < 2) begin
         record_fault(pie_pkg::ST_UNDER);
         return;
      end
      rhs = operands[depth_used-1];
      lhs = operands[depth_used-2];
      depth_used -= 2;
      case (c)
         pie_pkg::CHAR_PLUS:  res = lhs + rhs;
         pie_pkg::CHAR_MINUS: res = lhs - rhs;
         pie_pkg::CHAR_STAR:  res = lhs * rhs;
         default: begin
            if (rhs == '0) begin
               record_fault(pie_pkg::ST_DIVZ);
               res = '0;
            end else begin
               res = quotient_toward_zero(lhs, rhs);
            end
         end
      endcase
      push_operand(res);
   endfunction

   function automatic void flush_digits();
      if (in_digits) begin
         push_operand(digits_acc);
         digits_acc = '0;
         in_digits  = 1'b0;
      end
   endfunction

   // Advances the prediction by one character; returns 1 when a result is due.
   function automatic bit evaluate_char(input logic [pie_pkg::CHAR_W-1:0] c,
                                        input logic last, output eval_result_type res);
      res.value  = '0;
      res.status = pie_pkg::ST_OK;
      if (is_digit_char(c)) begin
         digits_acc = digits_acc * 10 + pie_pkg::WORD_W'(c - pie_pkg::CHAR_ZERO);
         in_digits  = 1'b1;
      end else begin
         flush_digits();
         if (is_operator_char(c)) apply_operator(c);
      end
      if (!last) return 1'b0;
      flush_digits();
      res.status = first_fault;
      if (first_fault == pie_pkg::ST_OK) begin
         if (depth_used == 0) res.status = pie_pkg::ST_EMPTY;
         else res.value = operands[depth_used-1];
      end
      clear_evaluation();
      return 1'b1;
   endfunction

   // Expression building: characters collect in expr_buf until the expression is queued.
   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
   endtask

   task automatic put_digits(input int count);
      for (int i = 0; i < count; i++)
         expr_buf.push_back(pie_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   // Mostly short numbers, with zeros for the divider and long runs that wrap.
   task automatic put_number();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) expr_buf.push_back(pie_pkg::CHAR_ZERO);
      else if (pick < 70) put_digits($urandom_range(1, 3));
      else if (pick < 92) put_digits($urandom_range(4, 10));
      else put_digits($urandom_range(11, 14));
   endtask

   // A space, or any byte that is neither a digit nor an operator.
   task automatic put_separator();
      logic [pie_pkg::CHAR_W-1:0] c;
      if ($urandom_range(0, 3) != 0) begin
         c = CHAR_SPACE;
      end else begin
         c = pie_pkg::CHAR_ZERO;
         while (is_digit_char(c) || is_operator_char(c))
            c = pie_pkg::CHAR_W'($urandom_range(0, 255));
      end
      expr_buf.push_back(c);
   endtask

   task automatic put_operator();
      expr_buf.push_back(OPERATOR_CHARS[$urandom_range(0, 3)]);
   endtask

   // A possibly negative operand, built as zero minus a number where needed.
   task automatic put_signed_operand();
      case ($urandom_range(0, 7))
         0: put_text("2147483648");
         1: put_text("0 1-");
         2, 3: begin
            put_text("0");
            put_separator();
            put_number();
            put_text("-");
         end
         default: put_number();
      endcase
   endtask

   // Well-formed postfix text that leaves keep words on the stack.
   task automatic build_rpn(input int numbers_left, input int push_pct, input int keep);
      int stacked;
      bit after_number;
      stacked      = 0;
      after_number = 1'b0;
      while (numbers_left > 0 || stacked > keep) begin
         if (numbers_left > 0 && (stacked < 2 || $urandom_range(0, 99) < push_pct)) begin
            if (after_number || $urandom_range(0, 7) == 0) put_separator();
            put_number();
            after_number = 1'b1;
            stacked++;
            numbers_left--;
         end else begin
            put_operator();
            after_number = 1'b0;
            stacked--;
         end
      end
   endtask

   // Moves the built expression to the request queue, marking its final character.
   task automatic commit_expr(input bit wait_idle);
      char_item_type item;
      if (expr_buf.size() == 0) put_separator();
      foreach (expr_buf[i]) begin
         item.code      = expr_buf[i];
         item.last      = (i == expr_buf.size() - 1);
         item.wait_idle = wait_idle && (i == 0);
         char_queue.push_back(item);
      end
      expr_buf.delete();
      expressions++;
   endtask

   // Random idling is off in a calm stretch and in the tail of the run.
   function automatic bit idling_allowed();
      return chars_sent < tail_start && !(chars_sent >= CALM_FIRST && chars_sent < CALM_LAST);
   endfunction

   // Request driver: updates the prediction on each accepted request, then offers the next.
   always @(posedge clock) begin : drive_requests
      bit              offer;
      eval_result_type outcome;
      offer = 1'b0;
      if (reset) begin
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (evaluate_char(req_ch.char_code, req_ch.end_of_expr, outcome))
               results_due.push_back(outcome);
            void'(char_queue.pop_front());
            chars_sent++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            offer = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
         end else if (char_queue.size() > 0 &&
                      !(char_queue[0].wait_idle && results_due.size() > 0)) begin
            req_ch.char_code   <= char_queue[0].code;
            req_ch.end_of_expr <= char_queue[0].last;
            offer = 1'b1;
            if (idling_allowed() && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
         end
      end
      req_ch.valid <= offer;
   end

   // Result monitor: compares each accepted result with the oldest prediction.
   always @(posedge clock) begin : check_results
      bit              take;
      eval_result_type want;
      take = 1'b1;
      if (reset) begin
         take      = 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got value %0d status %0d",
                        $time, rsp_ch.value, rsp_ch.status);
               failures++;
            end else begin
               want = results_due.pop_front();
               if (rsp_ch.value !== want.value) begin
                  $display("%0t: value mismatch, expected %0d, got %0d",
                           $time, $signed(want.value), rsp_ch.value);
                  failures++;
               end
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_ch.status);
                  failures++;
               end
               status_seen[want.status]++;
               results_checked++;
               // One long hold-off so that the block fills up and stalls its input.
               if (results_checked == 10) rsp_stall = LONG_HOLD_CYCLES;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            take = 1'b0;
         end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            rsp_stall = $urandom_range(0, 8);
            take      = 1'b0;
         end
      end
      rsp_ch.ready <= take;
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb failed");
            $finish;
         end
      end
   end

   // Stimulus and end of run.
   initial begin : run_test
      int pick;
      int directed_items;
      bit paused;
      req_ch.valid       = 1'b0;
      req_ch.char_code   = '0;
      req_ch.end_of_expr = 1'b0;
      rsp_ch.ready       = 1'b0;
      paused             = 1'b0;
      clear_evaluation();

      // Directed: byte 0 as separator and multiply.
      put_text("6");
      expr_buf.push_back(8'h00);
      put_text("3*");
      commit_expr(1'b0);
      // Byte 255 as separator, division by zero, then an underflow that is not reported.
      put_text("5");
      expr_buf.push_back(8'hFF);
      put_text("0/+");
      commit_expr(1'b0);
      // Lone operator underflows; lone space leaves the stack empty.
      put_text("-");
      commit_expr(1'b0);
      put_text(" ");
      commit_expr(1'b0);
      // Digit as final character, two words left over.
      put_text("1 2+3");
      commit_expr(1'b0);
      // Wrapping digit run gives the most negative word, divided by minus one.
      put_text("6442450944 0 1-/");
      commit_expr(1'b0);
      directed_items = char_queue.size();

      // Random: mostly well-formed expressions, mixed with deep stacks, broken text and noise.
      while (char_queue.size() < directed_items + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            build_rpn($urandom_range(1, 6), 60, ($urandom_range(0, 9) == 0) ? 2 : 1);
         end else if (pick < 67) begin
            build_rpn($urandom_range(13, 20), 95, 1);
         end else if (pick < 77) begin
            if ($urandom_range(0, 1)) put_operator();
            build_rpn($urandom_range(1, 4), 60, 1);
            if ($urandom_range(0, 1)) put_operator();
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 12))
               expr_buf.push_back(pie_pkg::CHAR_W'($urandom_range(0, 255)));
         end else if (pick < 94) begin
            put_signed_operand();
            put_separator();
            put_signed_operand();
            put_text("/");
         end else begin
            put_digits($urandom_range(11, 20));
            if ($urandom_range(0, 1)) put_text(" 7+");
         end
         // Halfway through, the sender waits once for every result to come back.
         commit_expr(!paused && char_queue.size() >= (directed_items + RANDOM_ITEMS) / 2);
         if (char_queue.size() >= (directed_items + RANDOM_ITEMS) / 2) paused = 1'b1;
      end
      tail_start = char_queue.size() - QUIET_TAIL_ITEMS;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || req_ch.valid) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters in %0d expressions and checked %0d results.",
               chars_sent, expressions, results_checked);
      $display({"Statuses seen: ok %0d, underflow %0d, overflow %0d, ",
                "divide by zero %0d, empty %0d."},
               status_seen[pie_pkg::ST_OK], status_seen[pie_pkg::ST_UNDER],
               status_seen[pie_pkg::ST_OVER], status_seen[pie_pkg::ST_DIVZ],
               status_seen[pie_pkg::ST_EMPTY]);
      if (failures == 0 && results_due.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
